[design/bfsk_pkg.sv]
// bfsk_pkg: shared types and codes for the binary fsk square-wave modulator
// no dependencies; imported by binary_fsk_square_wave_modulator_top and its testbench
`default_nettype none

package bfsk_pkg;

  // field widths fixed by the interface
  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int BITPOS_W   = 12;

  // parameter defaults
  localparam int BUFFER_BYTES_DEF = 256;
  localparam int COUNT_BITS_DEF   = 24;

  // input commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd2;

  // reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0] HALF_HIGH_RST  = 24'd12;
  localparam logic [CFG_DATA_W-1:0] HALF_LOW_RST   = 24'd16;
  localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RST = 24'd1000;

  // one result word
  typedef struct packed {
    logic drive_a;
    logic drive_b;
    logic busy;
    logic tone_high;
  } bfsk_res_t;

endpackage

`default_nettype wire

[design/binary_fsk_square_wave_modulator_top.sv]
// binary_fsk_square_wave_modulator_top: fsk modulator with byte buffer and output buffer
// depends on bfsk_pkg
//
// Binary FSK square-wave modulator. Each input word is a time tick, a buffer byte write
// or a start; every accepted word yields exactly one result word with the pin levels,
// busy and the selected tone after that word. The block takes one input word per clock
// while in_stall is low and works on it in a single pass: the buffer byte for the
// current bit position is fetched from the internal memory in advance (its read port
// follows the next bit position), so a tick that ends a bit period finds its byte
// already registered. Results go through a two-entry output buffer (output register
// plus skid register), so in_stall rises only when both are full; results are
// registered in them. Writes and starts are ignored while busy, a write beyond the
// buffer is dropped, and configuration must only be written while no result is pending.
`default_nettype none

module binary_fsk_square_wave_modulator_top
  import bfsk_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input words
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [CMD_W-1:0]       in_cmd,
  input  wire  [BYTE_W-1:0]      in_byte_addr,
  input  wire  [BYTE_W-1:0]      in_byte_value,
  input  wire  [LEN_W-1:0]       in_send_bytes,
  // result words
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic                   out_drive_a,
  output logic                   out_drive_b,
  output logic                   out_busy_res,
  output logic                   out_tone_high,
  // configuration writes
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [31:0] BUF_MAX = 32'(BUFFER_BYTES);

  // configuration registers
  logic [CFG_DATA_W-1:0] half_high_r, half_low_r, bit_period_r;

  // modulator state
  logic [BITPOS_W-1:0]   bit_pos_r, bit_pos_nxt;
  logic [LEN_W-1:0]      send_len_r, send_len_nxt;
  logic [COUNT_BITS-1:0] car_cnt_r, car_cnt_nxt;
  logic [COUNT_BITS-1:0] bit_cnt_r, bit_cnt_nxt;
  logic                  tone_r, tone_nxt;
  logic                  pin_a_r, pin_a_nxt;
  logic                  pin_b_r, pin_b_nxt;
  logic                  sending_r, sending_nxt;

  // byte buffer
  logic [BYTE_W-1:0]     mem [BUFFER_BYTES];
  logic [BYTE_W-1:0]     rd_byte_r;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [31:0]           rd_idx_wide, wr_idx_wide;
  logic                  wr_en;

  // output buffer
  logic                  out_valid_r, skid_valid_r;
  bfsk_res_t             out_res_r, skid_res_r, res_nxt;

  logic                  in_acc, out_take;

  // counter loads, masked to the counter width
  logic [31:0]           half_high_w, half_low_w, bit_period_w, len_wide;
  logic [COUNT_BITS-1:0] half_high_ld, half_low_ld, bit_period_ld;
  logic [LEN_W-1:0]      len_sat;

  logic                  bit_exp, car_exp, bit_val;
  logic [LEN_W-1:0]      byte_i;

  assign half_high_w   = 32'(half_high_r);
  assign half_low_w    = 32'(half_low_r);
  assign bit_period_w  = 32'(bit_period_r);
  assign half_high_ld  = half_high_w[COUNT_BITS-1:0];
  assign half_low_ld   = half_low_w[COUNT_BITS-1:0];
  assign bit_period_ld = bit_period_w[COUNT_BITS-1:0];

  // start length saturates to the buffer size
  assign len_wide = 32'(in_send_bytes);
  assign len_sat  = (len_wide > BUF_MAX) ? BUF_MAX[LEN_W-1:0] : in_send_bytes;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  assign cfg_ready = 1'b1;

  // counter expiry: a count of zero or one expires on this tick
  assign bit_exp = (bit_cnt_r == '0) || (bit_cnt_r == COUNT_BITS'(1));
  assign car_exp = (car_cnt_r == '0) || (car_cnt_r == COUNT_BITS'(1));
  assign byte_i  = bit_pos_r[BITPOS_W-1:3];
  assign bit_val = rd_byte_r[bit_pos_r[2:0]];

  // next-state logic for one accepted word
  always_comb begin
    bit_pos_nxt  = bit_pos_r;
    send_len_nxt = send_len_r;
    car_cnt_nxt  = car_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    tone_nxt     = tone_r;
    pin_a_nxt    = pin_a_r;
    pin_b_nxt    = pin_b_r;
    sending_nxt  = sending_r;
    wr_en        = 1'b0;
    if (in_acc) begin
      unique case (in_cmd)
        CMD_TICK: begin
          if (sending_r) begin
            bit_cnt_nxt = bit_exp ? '0 : bit_cnt_r - COUNT_BITS'(1);
            car_cnt_nxt = car_exp ? '0 : car_cnt_r - COUNT_BITS'(1);
            if (bit_exp && (byte_i >= send_len_r)) begin
              // bits exhausted: both pins low, carrier does nothing
              pin_a_nxt   = 1'b0;
              pin_b_nxt   = 1'b0;
              sending_nxt = 1'b0;
              car_cnt_nxt = '0;
              bit_cnt_nxt = '0;
            end else begin
              if (bit_exp) begin
                tone_nxt    = bit_val;
                bit_pos_nxt = bit_pos_r + BITPOS_W'(1);
                bit_cnt_nxt = bit_period_ld;
              end
              if (car_exp) begin
                // reload uses the tone just selected on a shared expiry
                pin_a_nxt   = !pin_a_r;
                pin_b_nxt   = pin_a_r;
                car_cnt_nxt = tone_nxt ? half_high_ld : half_low_ld;
              end
            end
          end
        end
        CMD_WRITE: begin
          wr_en = !sending_r && (wr_idx_wide < BUF_MAX);
        end
        CMD_START: begin
          if (!sending_r) begin
            send_len_nxt = len_sat;
            bit_pos_nxt  = '0;
            tone_nxt     = 1'b0;
            pin_a_nxt    = 1'b1;
            pin_b_nxt    = 1'b0;
            car_cnt_nxt  = half_low_ld;
            bit_cnt_nxt  = bit_period_ld;
            sending_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt.drive_a   = pin_a_nxt;
    res_nxt.drive_b   = pin_b_nxt;
    res_nxt.busy      = sending_nxt;
    res_nxt.tone_high = tone_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r  <= '0;
      send_len_r <= '0;
      car_cnt_r  <= '0;
      bit_cnt_r  <= '0;
      tone_r     <= 1'b0;
      pin_a_r    <= 1'b0;
      pin_b_r    <= 1'b0;
      sending_r  <= 1'b0;
    end else begin
      bit_pos_r  <= bit_pos_nxt;
      send_len_r <= send_len_nxt;
      car_cnt_r  <= car_cnt_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      tone_r     <= tone_nxt;
      pin_a_r    <= pin_a_nxt;
      pin_b_r    <= pin_b_nxt;
      sending_r  <= sending_nxt;
    end
  end

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_high_r  <= HALF_HIGH_RST;
      half_low_r   <= HALF_LOW_RST;
      bit_period_r <= BIT_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_HIGH:  half_high_r  <= cfg_data;
        REG_HALF_LOW:   half_low_r   <= cfg_data;
        REG_BIT_PERIOD: bit_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte buffer: read port tracks the next bit position so the byte is
  // registered before the tick that needs it
  assign rd_idx_wide = 32'(bit_pos_nxt[BITPOS_W-1:3]);
  assign rd_addr     = rd_idx_wide[ADDR_W-1:0];
  assign wr_idx_wide = 32'(in_byte_addr);
  assign wr_addr     = wr_idx_wide[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_byte_value;
    end
    rd_byte_r <= mem[rd_addr];
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        out_valid_r  <= skid_valid_r || in_acc;
        skid_valid_r <= skid_valid_r && in_acc;
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (in_acc) begin
        out_res_r <= res_nxt;
      end
    end
    if (in_acc && (skid_valid_r || (out_valid_r && !out_take))) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive_a   = out_res_r.drive_a;
  assign out_drive_b   = out_res_r.drive_b;
  assign out_busy_res  = out_res_r.busy;
  assign out_tone_high = out_res_r.tone_high;

  // pins are complementary while sending
  a_pins_complement: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> (pin_a_r != pin_b_r))
    else $error("pins not complementary while sending");

  // both pins low when idle
  a_idle_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (!pin_a_r && !pin_b_r))
    else $error("pins driven while idle");

  // skid entry only holds a word behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // byte index never runs past the send length
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> (byte_i <= send_len_r))
    else $error("bit position past send length");

  // end of a send leaves both counters cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(sending_r) |-> (car_cnt_r == '0 && bit_cnt_r == '0))
    else $error("counters not cleared at end of send");

endmodule

`default_nettype wire

[test/tb_binary_fsk_square_wave_modulator_top.sv]
// testbench for binary_fsk_square_wave_modulator_top: a word-level model predicts the pin
// levels, busy and tone after every input word and the monitor checks each result word
// depends on bfsk_pkg and binary_fsk_square_wave_modulator_top
`timescale 1ns / 1ps

module tb_binary_fsk_square_wave_modulator_top
  import bfsk_pkg::*;
();

  // command code the block does not use
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // two copies of the modulator model: one runs ahead while words are queued (so the
  // generator knows when writes and starts will be taken), one follows accepted words
  localparam int LOOKAHEAD = 0;
  localparam int ACCEPTED  = 1;

  localparam logic [CFG_DATA_W-1:0] PERIOD_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  nbytes;
  } fsk_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = '0;
  logic [BYTE_W-1:0]     in_byte_addr = '0;
  logic [BYTE_W-1:0]     in_byte_value = '0;
  logic [LEN_W-1:0]      in_send_bytes = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_drive_a;
  logic                  out_drive_b;
  logic                  out_busy_res;
  logic                  out_tone_high;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  binary_fsk_square_wave_modulator_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_byte_addr  (in_byte_addr),
    .in_byte_value (in_byte_value),
    .in_send_bytes (in_send_bytes),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_a   (out_drive_a),
    .out_drive_b   (out_drive_b),
    .out_busy_res  (out_busy_res),
    .out_tone_high (out_tone_high),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // modulator state, one row per model copy
  logic [7:0]            byte_mem [2][256];
  logic [BITPOS_W-1:0]   bit_pos  [2];
  logic [LEN_W-1:0]      send_len [2];
  logic [CFG_DATA_W-1:0] car_cnt  [2];
  logic [CFG_DATA_W-1:0] bit_cnt  [2];
  logic                  tone_hi  [2];
  logic                  pin_a    [2];
  logic                  pin_b    [2];
  logic                  sending  [2];
  logic [CFG_DATA_W-1:0] half_hi  [2];
  logic [CFG_DATA_W-1:0] half_lo  [2];
  logic [CFG_DATA_W-1:0] bit_len  [2];

  fsk_word_t pending_words[$];
  bfsk_res_t expected_levels[$];

  int items_made = 0;
  int results_seen = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // applies one word to a model copy and returns the levels after it
  function automatic bfsk_res_t advance_modulator(input int m, input fsk_word_t w);
    bfsk_res_t r;
    logic      bit_done;
    logic      car_done;
    case (w.cmd)
      CMD_TICK: begin
        // a tick while idle changes nothing
        if (sending[m]) begin
          bit_done = (bit_cnt[m] <= 1);
          bit_cnt[m] = bit_done ? '0 : bit_cnt[m] - 1'b1;
          car_done = (car_cnt[m] <= 1);
          car_cnt[m] = car_done ? '0 : car_cnt[m] - 1'b1;
          if (bit_done && bit_pos[m][BITPOS_W-1:3] >= send_len[m]) begin
            // bits ran out: pins low, carrier does nothing on this tick
            pin_a[m] = 1'b0;
            pin_b[m] = 1'b0;
            sending[m] = 1'b0;
            car_cnt[m] = '0;
            bit_cnt[m] = '0;
          end else begin
            // bit counter acts first so a same-tick carrier reload sees the new tone
            if (bit_done) begin
              tone_hi[m] = byte_mem[m][bit_pos[m][10:3]][bit_pos[m][2:0]];
              bit_pos[m] = bit_pos[m] + 1'b1;
              bit_cnt[m] = bit_len[m];
            end
            if (car_done) begin
              pin_a[m] = ~pin_a[m];
              pin_b[m] = ~pin_a[m];
              car_cnt[m] = tone_hi[m] ? half_hi[m] : half_lo[m];
            end
          end
        end
      end
      CMD_WRITE: begin
        if (!sending[m]) byte_mem[m][w.addr] = w.value;
      end
      CMD_START: begin
        if (!sending[m]) begin
          send_len[m] = (w.nbytes > 256) ? LEN_W'(256) : w.nbytes;
          bit_pos[m] = '0;
          tone_hi[m] = 1'b0;
          pin_a[m] = 1'b1;
          pin_b[m] = 1'b0;
          car_cnt[m] = half_lo[m];
          bit_cnt[m] = bit_len[m];
          sending[m] = 1'b1;
        end
      end
      default: ;
    endcase
    r.drive_a = pin_a[m];
    r.drive_b = pin_b[m];
    r.busy = sending[m];
    r.tone_high = tone_hi[m];
    return r;
  endfunction

  function automatic void store_period(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    for (int m = 0; m < 2; m++) begin
      case (idx)
        REG_HALF_HIGH:  half_hi[m] = val;
        REG_HALF_LOW:   half_lo[m] = val;
        REG_BIT_PERIOD: bit_len[m] = val;
        default: ;
      endcase
    end
  endfunction

  function automatic void clear_models();
    for (int m = 0; m < 2; m++) begin
      for (int a = 0; a < 256; a++) byte_mem[m][a] = '0;
      bit_pos[m] = '0;
      send_len[m] = '0;
      car_cnt[m] = '0;
      bit_cnt[m] = '0;
      tone_hi[m] = 1'b0;
      pin_a[m] = 1'b0;
      pin_b[m] = 1'b0;
      sending[m] = 1'b0;
    end
    store_period(REG_HALF_HIGH, HALF_HIGH_RST);
    store_period(REG_HALF_LOW, HALF_LOW_RST);
    store_period(REG_BIT_PERIOD, BIT_PERIOD_RST);
  endfunction

  // queue a word for the driver; the lookahead copy follows it right away
  function automatic void queue_word(input logic [CMD_W-1:0] cmd, input int addr,
                                     input int val, input int nbytes);
    fsk_word_t w;
    w.cmd = cmd;
    w.addr = addr[BYTE_W-1:0];
    w.value = val[BYTE_W-1:0];
    w.nbytes = nbytes[LEN_W-1:0];
    void'(advance_modulator(LOOKAHEAD, w));
    pending_words.push_back(w);
    items_made++;
  endfunction

  function automatic void queue_random(input logic [CMD_W-1:0] cmd, input int nbytes);
    queue_word(cmd, $urandom_range(0, 255), $urandom_range(0, 255), nbytes);
  endfunction

  // ticks with random payload until the lookahead copy has finished its send
  function automatic void tick_until_quiet();
    while (sending[LOOKAHEAD]) queue_random(CMD_TICK, $urandom_range(0, 511));
  endfunction

  // well-formed traffic: a few byte writes, a start, then ticks through the send,
  // with the odd ignored write, ignored start, idle tick or unused command mixed in
  function automatic void run_traffic(input int count);
    int target;
    target = items_made + count;
    while (items_made < target) begin
      if (!sending[LOOKAHEAD]) begin
        repeat ($urandom_range(0, 3)) begin
          // mostly the bytes a short send will read
          queue_word(CMD_WRITE, $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 511));
        end
        if ($urandom_range(0, 9) == 0) queue_random(CMD_UNUSED, $urandom_range(0, 511));
        if ($urandom_range(0, 9) == 0) queue_random(CMD_TICK, $urandom_range(0, 511));
        queue_random(CMD_START, $urandom_range(0, 3));
      end
      while (sending[LOOKAHEAD] && items_made < target) begin
        case ($urandom_range(0, 19))
          0:       queue_random(CMD_WRITE, $urandom_range(0, 511));
          1:       queue_random(CMD_START, $urandom_range(0, 511));
          2:       queue_random(CMD_UNUSED, $urandom_range(0, 511));
          default: queue_random(CMD_TICK, $urandom_range(0, 511));
        endcase
      end
    end
  endfunction

  // wait until every queued word went in and every result came back
  task automatic drain_results();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_levels.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    store_period(idx, val);
  endtask

  task automatic program_periods(input logic [CFG_DATA_W-1:0] hi, input logic [CFG_DATA_W-1:0] lo,
                                 input logic [CFG_DATA_W-1:0] bits);
    write_reg(REG_HALF_HIGH, hi);
    write_reg(REG_HALF_LOW, lo);
    write_reg(REG_BIT_PERIOD, bits);
  endtask

  // driver: presents queued words, predicts the result of each accepted one
  fsk_word_t cur_word;
  int        send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_levels.push_back(advance_modulator(ACCEPTED, cur_word));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_word.cmd;
          in_byte_addr <= cur_word.addr;
          in_byte_value <= cur_word.value;
          in_send_bytes <= cur_word.nbytes;
          // idle burst after this word goes in
          if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result words and drives the receiver stall
  bfsk_res_t got_levels;
  bfsk_res_t want_levels;
  int        recv_gap = 0;
  int        long_hold = 0;
  logic      long_hold_done = 1'b0;
  logic      stall_next;

  // one long hold-off early on so the output buffer fills and in_stall rises
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold <= 0;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
    end else if (!long_hold_done && results_seen >= 400) begin
      long_hold <= 300;
      long_hold_done <= 1'b1;
    end
  end

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic compare_level(input string name, input logic want, input logic got);
    if (want !== got) begin
      flag_error($sformatf("result %0d %s: expected %b, got %b", results_seen, name, want, got));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got_levels.drive_a = out_drive_a;
        got_levels.drive_b = out_drive_b;
        got_levels.busy = out_busy_res;
        got_levels.tone_high = out_tone_high;
        if (expected_levels.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected: %b",
                               results_seen, got_levels));
        end else begin
          want_levels = expected_levels.pop_front();
          compare_level("drive_a", want_levels.drive_a, got_levels.drive_a);
          compare_level("drive_b", want_levels.drive_b, got_levels.drive_b);
          compare_level("busy", want_levels.busy, got_levels.busy);
          compare_level("tone_high", want_levels.tone_high, got_levels.tone_high);
        end
      end
      if (long_hold != 0) begin
        stall_next = 1'b1;
      end else if (recv_gap != 0) begin
        recv_gap--;
        stall_next = 1'b1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 7);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // stimulus and phases
  initial begin
    clear_models();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 25;

    // short periods so a whole send fits in a handful of ticks; the low-tone carrier (2)
    // and the bit counter (1) expire together on every other tick
    program_periods(24'd1, 24'd2, 24'd1);
    queue_word(CMD_TICK, 0, 0, 0);                // tick while idle
    queue_word(CMD_UNUSED, 255, 255, 511);        // unused command, all field bits high
    queue_word(CMD_WRITE, 0, 8'hA5, 0);
    queue_word(CMD_WRITE, 1, 8'hFF, 256);
    queue_word(CMD_WRITE, 255, 8'h00, 0);
    queue_word(CMD_START, 0, 0, 0);               // zero length: lead bit only
    queue_word(CMD_WRITE, 2, 8'h3C, 0);           // dropped while busy
    queue_word(CMD_START, 255, 255, 511);         // dropped while busy
    tick_until_quiet();
    queue_word(CMD_START, 0, 0, 1);               // one byte, tones follow 8'hA5
    tick_until_quiet();
    drain_results();

    // fill the whole buffer, then random traffic; the long hold-off lands here
    program_periods(24'd3, 24'd5, 24'd4);
    tick_until_quiet();
    for (int a = 0; a < 256; a++) begin
      queue_word(CMD_WRITE, a, $urandom_range(0, 255), $urandom_range(0, 511));
    end
    run_traffic(400);
    drain_results();

    // largest half periods: carrier never expires within a bit
    program_periods(PERIOD_MAX, PERIOD_MAX, 24'd3);
    run_traffic(300);
    drain_results();

    // zero half periods act as one tick; no idling on either side here
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_periods(24'd0, 24'd0, 24'd2);
    run_traffic(300);
    drain_results();

    // zero bit period acts as one tick
    send_idle_pct = 30;
    recv_idle_pct = 30;
    program_periods(24'd1, 24'd1, 24'd0);
    run_traffic(300);
    drain_results();

    program_periods(24'd7, 24'd2, 24'd6);
    run_traffic(200);
    drain_results();

    // last part, no idling: finish the open send under the short bit period, then the
    // longest bit period and an oversized length, so the block stays in its lead bit
    // while the carrier keeps toggling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    tick_until_quiet();
    drain_results();
    program_periods(24'd2, 24'd3, PERIOD_MAX);
    queue_word(CMD_START, 0, 0, 511);
    run_traffic(150);
    drain_results();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("tb_binary_fsk_square_wave_modulator_top passed");
    end else begin
      $display("tb_binary_fsk_square_wave_modulator_top failed");
    end
    $finish;
  end

  // run limit far above the slowest correct run
  initial begin
    #2_000_000;
    $display("tb_binary_fsk_square_wave_modulator_top failed");
    $finish;
  end

endmodule
